FILE: rtl/core/kalman_angle_bias_filter_macros.svh
// ----------------------------------------------------------------------------
// kalman angle/bias filter assertion macros
// short forms for the clocked checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef KALMAN_ANGLE_BIAS_FILTER_MACROS_SVH
`define KALMAN_ANGLE_BIAS_FILTER_MACROS_SVH

// same-cycle implication, checked out of reset
`define KABF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define KABF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/kabf_pkg.sv
// ----------------------------------------------------------------------------
// kabf_pkg
// shared types and constants of the kalman angle/bias filter
// ----------------------------------------------------------------------------
package kabf_pkg;

    localparam int KABF_DATA_WIDTH = 32;
    localparam int KABF_FRAC       = 24;
    localparam int KABF_ADDR_W     = 4;
    localparam int KABF_NOISE_W    = 31;

    // register map, word index
    localparam logic [1:0] KABF_REG_APN = 2'd0;
    localparam logic [1:0] KABF_REG_BPN = 2'd1;
    localparam logic [1:0] KABF_REG_MN  = 2'd2;

    localparam logic [KABF_NOISE_W-1:0] KABF_APN_RST = 31'd335544;
    localparam logic [KABF_NOISE_W-1:0] KABF_BPN_RST = 31'd50332;
    localparam logic [KABF_NOISE_W-1:0] KABF_MN_RST  = 31'd503316;

    // 90 degrees in q16.16
    localparam logic signed [31:0] KABF_NINETY = 32'sd5898240;

    // dt = ms*16777 + floor((ms*216 + 500) / 1000), the divide by reciprocal
    localparam logic [14:0] KABF_DT_WHOLE = 15'd16777;
    localparam logic [7:0]  KABF_DT_FRAC  = 8'd216;
    localparam logic [9:0]  KABF_DT_HALF  = 10'd500;
    localparam logic [24:0] KABF_DT_RECIP = 25'd17179870;
    localparam int          KABF_DT_SHIFT = 34;
    localparam int          KABF_DTV_W    = 24;
    localparam int          KABF_DTP_W    = 49;
    localparam int          KABF_DT_W     = 31;

    typedef struct packed {
        logic signed [31:0] measured_angle;
        logic signed [31:0] measured_rate;
        logic [15:0]        elapsed_ms;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] filtered_angle;
        logic               snapped;
    } t_out_req;

endpackage

FILE: rtl/core/kalman_angle_bias_filter.sv
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter
// two-state kalman filter (tilt angle and gyro bias) on a shared multiplier
// and a bit-serial divider under a micro-sequencer
// ----------------------------------------------------------------------------
// One request carries an accelerometer angle, a gyro rate (both q16.16) and
// the elapsed milliseconds; one result request returns the filtered angle and
// a flag for the +-90 degree wrap snap. The block works on one request at a
// time; the time from acceptance to a loaded result is set by the two gain
// divisions, which make one quotient bit per clock, and by ten products
// through the single shared multiplier. A division whose innovation variance
// is not positive is skipped, and a snap skips the update and only moves the
// angle. A finished result waits in the output register, so the next request
// is taken while it is still stalled downstream. Noise registers are written
// over the apb port; the user must write them only while the block is idle,
// which the block itself does not enforce.
// ----------------------------------------------------------------------------
`include "kalman_angle_bias_filter_macros.svh"

module kalman_angle_bias_filter
    import kabf_pkg::*;
#(
    parameter int DATA_WIDTH = KABF_DATA_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_req                i_in_req,
    // result channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_req               o_out_req,
    // apb configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [KABF_ADDR_W-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int W  = DATA_WIDTH;
    // operand width: wide enough for state words, raw inputs and dt
    localparam int OW = (W > 32) ? W : 32;
    localparam int PW = 2 * OW;
    localparam int CW = $clog2(W);

    localparam logic signed [W-1:0] W_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] W_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] NINETY_W = W'(KABF_NINETY);
    localparam logic signed [W-1:0] NINETY_WN = -NINETY_W;
    localparam logic signed [OW:0]  OUT_HI = (OW+1)'(64'sd2147483647);
    localparam logic signed [OW:0]  OUT_LO = (OW+1)'(-64'sd2147483648);
    localparam logic [PW:0]         RND_HALF = (PW+1)'(1) << (KABF_FRAC - 1);
    localparam logic [PW:0]         LIM_POS = (PW+1)'(W_MAX);

    typedef enum logic [3:0] {
        S_IDLE, S_DT1, S_DT2, S_DT3, S_RUN, S_RND, S_DIV, S_DIVW, S_DONE
    } t_state;

    typedef enum logic [1:0] { K_ADD, K_MUL, K_DIV } t_kind;

    typedef enum logic [4:0] {
        O_ZERO, O_DT, O_RIN, O_RATE, O_ANG, O_BIAS, O_P0, O_P1, O_P2, O_P3,
        O_MQ, O_DP, O_T, O_QA, O_QB, O_RM, O_MEAS, O_Y, O_K0, O_K1
    } t_opd;

    typedef enum logic [3:0] {
        D_RATE, D_ANG, D_BIAS, D_P0, D_P1, D_P2, D_P3, D_DP, D_T, D_S, D_Y,
        D_K0, D_K1
    } t_dst;

    typedef struct packed {
        t_kind kind;
        t_opd  opa;
        t_opd  opb;
        logic  sub;
        t_dst  dst;
        logic  last;
    } t_uop;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [KABF_NOISE_W-1:0] r_qa, r_qb, r_rm;
    logic                    cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa <= KABF_APN_RST;
            r_qb <= KABF_BPN_RST;
            r_rm <= KABF_MN_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                KABF_REG_APN: r_qa <= pwdata[KABF_NOISE_W-1:0];
                KABF_REG_BPN: r_qb <= pwdata[KABF_NOISE_W-1:0];
                KABF_REG_MN:  r_rm <= pwdata[KABF_NOISE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            KABF_REG_APN: prdata = {1'b0, r_qa};
            KABF_REG_BPN: prdata = {1'b0, r_qb};
            KABF_REG_MN:  prdata = {1'b0, r_rm};
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    t_state r_state;
    logic [4:0] r_step;
    logic r_snap;
    logic r_out_valid;
    t_out_req r_out;

    // filter state
    logic signed [W-1:0] r_ang, r_bias, r_p0, r_p1, r_p2, r_p3;
    // scratch words
    logic signed [W-1:0] r_rate, r_dp, r_t, r_s, r_y, r_k0, r_k1, r_mq;

    // captured request
    logic signed [31:0] r_meas, r_rin;
    logic [15:0] r_ms;

    // dt pipeline
    logic [KABF_DT_W-1:0]  r_dta, r_dt;
    logic [KABF_DTV_W-1:0] r_dtv;
    logic [KABF_DTP_W-1:0] r_dtp;

    // multiplier
    logic [PW-1:0] r_prod;
    logic          r_neg;

    // divider
    logic [W-1:0]  r_rem, r_dnum, r_quo;
    logic          r_dovf;
    logic [CW-1:0] r_cnt;

    // saturate a widened value to the state width
    function automatic logic signed [W-1:0] sat_w(input logic signed [OW:0] x);
        logic signed [OW:0] hi;
        logic signed [OW:0] lo;
        hi = (OW+1)'(W_MAX);
        lo = (OW+1)'(W_MIN);
        if (x > hi) return W_MAX;
        if (x < lo) return W_MIN;
        return x[W-1:0];
    endfunction

    function automatic t_uop mk(input t_kind k, input t_opd a, input t_opd b,
                                input logic s, input t_dst d, input logic l);
        t_uop u;
        u.kind = k;
        u.opa  = a;
        u.opb  = b;
        u.sub  = s;
        u.dst  = d;
        u.last = l;
        return u;
    endfunction

    // micro program of one filter update
    function automatic t_uop decode(input logic [4:0] step);
        t_uop u;
        case (step)
            5'd0:  u = mk(K_ADD, O_RIN,  O_BIAS, 1'b1, D_RATE, 1'b0);
            5'd1:  u = mk(K_MUL, O_DT,   O_RATE, 1'b0, D_ANG,  1'b0);
            5'd2:  u = mk(K_ADD, O_ANG,  O_MQ,   1'b0, D_ANG,  1'b0);
            5'd3:  u = mk(K_MUL, O_DT,   O_P3,   1'b0, D_DP,   1'b0);
            5'd4:  u = mk(K_ADD, O_MQ,   O_ZERO, 1'b0, D_DP,   1'b0);
            5'd5:  u = mk(K_ADD, O_DP,   O_P1,   1'b1, D_T,    1'b0);
            5'd6:  u = mk(K_ADD, O_T,    O_P2,   1'b1, D_T,    1'b0);
            5'd7:  u = mk(K_ADD, O_T,    O_QA,   1'b0, D_T,    1'b0);
            5'd8:  u = mk(K_MUL, O_DT,   O_T,    1'b0, D_P0,   1'b0);
            5'd9:  u = mk(K_ADD, O_P0,   O_MQ,   1'b0, D_P0,   1'b0);
            5'd10: u = mk(K_ADD, O_P1,   O_DP,   1'b1, D_P1,   1'b0);
            5'd11: u = mk(K_ADD, O_P2,   O_DP,   1'b1, D_P2,   1'b0);
            5'd12: u = mk(K_MUL, O_QB,   O_DT,   1'b0, D_P3,   1'b0);
            5'd13: u = mk(K_ADD, O_P3,   O_MQ,   1'b0, D_P3,   1'b0);
            5'd14: u = mk(K_ADD, O_P0,   O_RM,   1'b0, D_S,    1'b0);
            5'd15: u = mk(K_ADD, O_MEAS, O_ANG,  1'b1, D_Y,    1'b0);
            5'd16: u = mk(K_DIV, O_P0,   O_ZERO, 1'b0, D_K0,   1'b0);
            5'd17: u = mk(K_DIV, O_P2,   O_ZERO, 1'b0, D_K1,   1'b0);
            5'd18: u = mk(K_MUL, O_K0,   O_Y,    1'b0, D_ANG,  1'b0);
            5'd19: u = mk(K_ADD, O_ANG,  O_MQ,   1'b0, D_ANG,  1'b0);
            5'd20: u = mk(K_MUL, O_K1,   O_Y,    1'b0, D_BIAS, 1'b0);
            5'd21: u = mk(K_ADD, O_BIAS, O_MQ,   1'b0, D_BIAS, 1'b0);
            // keep the predicted covariance row before it is overwritten
            5'd22: u = mk(K_ADD, O_P0,   O_ZERO, 1'b0, D_T,    1'b0);
            5'd23: u = mk(K_ADD, O_P1,   O_ZERO, 1'b0, D_DP,   1'b0);
            5'd24: u = mk(K_MUL, O_K0,   O_T,    1'b0, D_P0,   1'b0);
            5'd25: u = mk(K_ADD, O_P0,   O_MQ,   1'b1, D_P0,   1'b0);
            5'd26: u = mk(K_MUL, O_K0,   O_DP,   1'b0, D_P1,   1'b0);
            5'd27: u = mk(K_ADD, O_P1,   O_MQ,   1'b1, D_P1,   1'b0);
            5'd28: u = mk(K_MUL, O_K1,   O_T,    1'b0, D_P2,   1'b0);
            5'd29: u = mk(K_ADD, O_P2,   O_MQ,   1'b1, D_P2,   1'b0);
            5'd30: u = mk(K_MUL, O_K1,   O_DP,   1'b0, D_P3,   1'b0);
            5'd31: u = mk(K_ADD, O_P3,   O_MQ,   1'b1, D_P3,   1'b1);
            default: u = mk(K_ADD, O_ZERO, O_ZERO, 1'b0, D_T, 1'b1);
        endcase
        return u;
    endfunction

    // operand select, everything widened to the operand width
    function automatic logic signed [OW-1:0] opnd(input t_opd sel);
        logic signed [OW-1:0] v;
        case (sel)
            O_ZERO: v = '0;
            O_DT:   v = OW'({1'b0, r_dt});
            O_RIN:  v = OW'(r_rin);
            O_RATE: v = OW'(r_rate);
            O_ANG:  v = OW'(r_ang);
            O_BIAS: v = OW'(r_bias);
            O_P0:   v = OW'(r_p0);
            O_P1:   v = OW'(r_p1);
            O_P2:   v = OW'(r_p2);
            O_P3:   v = OW'(r_p3);
            O_MQ:   v = OW'(r_mq);
            O_DP:   v = OW'(r_dp);
            O_T:    v = OW'(r_t);
            O_QA:   v = OW'(sat_w((OW+1)'({1'b0, r_qa})));
            O_QB:   v = OW'(sat_w((OW+1)'({1'b0, r_qb})));
            O_RM:   v = OW'(sat_w((OW+1)'({1'b0, r_rm})));
            O_MEAS: v = OW'(r_meas);
            O_Y:    v = OW'(r_y);
            O_K0:   v = OW'(r_k0);
            O_K1:   v = OW'(r_k1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // shared arithmetic
    // ------------------------------------------------------------------
    t_uop                uop;
    logic signed [OW-1:0] opa, opb;
    logic signed [OW:0]  add_sum;
    logic signed [W-1:0] add_res;
    logic [OW-1:0]       mag_a, mag_b;
    logic [PW:0]         rnd_q, rnd_lim, rnd_m;
    logic signed [W-1:0] rnd_res;
    logic                s_pos;
    logic [W-1:0]        div_n, div_un;
    logic [W:0]          div_r2;
    logic                div_ge;
    logic [W-1:0]        dq_lim, dq_m;
    logic signed [W-1:0] dq_res;
    logic                wr_en;
    logic signed [W-1:0] wr_val;
    logic signed [OW:0]  ang_ext;
    logic [31:0]         ang_out;
    logic                in_acc, snap_now, out_free;

    assign uop = decode(r_step);
    assign opa = opnd(uop.opa);
    assign opb = opnd(uop.opb);

    // saturating add / subtract, one per clock
    assign add_sum = uop.sub ? (OW+1)'(opa) - (OW+1)'(opb)
                             : (OW+1)'(opa) + (OW+1)'(opb);
    assign add_res = sat_w(add_sum);

    // sign-magnitude multiply, product rounded half away from zero
    assign mag_a = opa[OW-1] ? OW'(-opa) : OW'(opa);
    assign mag_b = opb[OW-1] ? OW'(-opb) : OW'(opb);

    assign rnd_q   = ((PW+1)'(r_prod) + RND_HALF) >> KABF_FRAC;
    assign rnd_lim = r_neg ? LIM_POS + (PW+1)'(1) : LIM_POS;
    assign rnd_m   = (rnd_q > rnd_lim) ? rnd_lim : rnd_q;
    assign rnd_res = r_neg ? W'((PW+1)'(0) - rnd_m) : W'(rnd_m);

    // restoring divider, one quotient bit per clock
    assign s_pos  = !r_s[W-1] && (r_s != '0);
    assign div_n  = opa[W-1:0];
    assign div_un = div_n[W-1] ? W'(-div_n) : div_n;
    assign div_r2 = {r_rem, r_dnum[W-1]};
    assign div_ge = div_r2 >= {1'b0, r_s};

    assign dq_lim = r_neg ? W'(W_MIN) : W'(W_MAX);
    assign dq_m   = (r_dovf || (r_quo > dq_lim)) ? dq_lim : r_quo;
    assign dq_res = r_neg ? W'(-dq_m) : W'(dq_m);

    // write-back into the destination of the current step
    always_comb begin
        wr_en  = 1'b0;
        wr_val = add_res;
        case (r_state)
            S_RUN: begin
                if (uop.kind == K_ADD) begin
                    wr_en = 1'b1;
                end else if (uop.kind == K_DIV && !s_pos) begin
                    // gain is zero when the innovation variance is not positive
                    wr_en  = 1'b1;
                    wr_val = '0;
                end
            end
            S_DIVW: begin
                wr_en  = 1'b1;
                wr_val = dq_res;
            end
            default: ;
        endcase
    end

    // snap test against the estimate before the update
    assign snap_now = (i_in_req.measured_angle < -KABF_NINETY && r_ang > NINETY_W) ||
                      (i_in_req.measured_angle > KABF_NINETY && r_ang < NINETY_WN);

    // result angle clamped to 32 bits
    assign ang_ext = (OW+1)'(r_ang);
    assign ang_out = (ang_ext > OUT_HI) ? 32'h7FFF_FFFF :
                     (ang_ext < OUT_LO) ? 32'h8000_0000 : ang_ext[31:0];

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_snap      <= 1'b0;
            r_ang       <= '0;
            r_bias      <= '0;
            r_p0        <= '0;
            r_p1        <= '0;
            r_p2        <= '0;
            r_p3        <= '0;
        end else begin
            // result loaded, or taken downstream
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (wr_en) begin
                case (uop.dst)
                    D_RATE: r_rate <= wr_val;
                    D_ANG:  r_ang  <= wr_val;
                    D_BIAS: r_bias <= wr_val;
                    D_P0:   r_p0   <= wr_val;
                    D_P1:   r_p1   <= wr_val;
                    D_P2:   r_p2   <= wr_val;
                    D_P3:   r_p3   <= wr_val;
                    D_DP:   r_dp   <= wr_val;
                    D_T:    r_t    <= wr_val;
                    D_S:    r_s    <= wr_val;
                    D_Y:    r_y    <= wr_val;
                    D_K0:   r_k0   <= wr_val;
                    D_K1:   r_k1   <= wr_val;
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_meas  <= i_in_req.measured_angle;
                        r_rin   <= i_in_req.measured_rate;
                        r_ms    <= i_in_req.elapsed_ms;
                        r_snap  <= snap_now;
                        r_step  <= '0;
                        r_state <= S_DT1;
                    end
                end
                S_DT1: begin
                    if (r_snap) begin
                        // wrap snap: only the angle moves
                        r_ang   <= sat_w((OW+1)'(r_meas));
                        r_state <= S_DONE;
                    end else begin
                        r_dta   <= KABF_DT_W'(r_ms) * KABF_DT_W'(KABF_DT_WHOLE);
                        r_dtv   <= KABF_DTV_W'(r_ms) * KABF_DTV_W'(KABF_DT_FRAC)
                                   + KABF_DTV_W'(KABF_DT_HALF);
                        r_state <= S_DT2;
                    end
                end
                S_DT2: begin
                    r_dtp   <= KABF_DTP_W'(r_dtv) * KABF_DTP_W'(KABF_DT_RECIP);
                    r_state <= S_DT3;
                end
                S_DT3: begin
                    r_dt    <= r_dta + KABF_DT_W'(r_dtp >> KABF_DT_SHIFT);
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    case (uop.kind)
                        K_MUL: begin
                            r_prod  <= PW'(mag_a) * PW'(mag_b);
                            r_neg   <= opa[OW-1] ^ opb[OW-1];
                            r_state <= S_RND;
                        end
                        K_DIV: begin
                            if (s_pos) begin
                                r_neg   <= div_n[W-1];
                                r_dnum  <= W'({div_un, KABF_FRAC'(0)});
                                r_rem   <= div_un >> (W - KABF_FRAC);
                                r_dovf  <= (div_un >> (W - KABF_FRAC)) >= r_s;
                                r_quo   <= '0;
                                r_cnt   <= '0;
                                r_state <= S_DIV;
                            end else begin
                                r_step <= r_step + 5'd1;
                            end
                        end
                        default: begin
                            if (uop.last) begin
                                r_step  <= '0;
                                r_state <= S_DONE;
                            end else begin
                                r_step <= r_step + 5'd1;
                            end
                        end
                    endcase
                end
                S_RND: begin
                    r_mq    <= rnd_res;
                    r_step  <= r_step + 5'd1;
                    r_state <= S_RUN;
                end
                S_DIV: begin
                    r_rem   <= div_ge ? W'(div_r2 - {1'b0, r_s}) : div_r2[W-1:0];
                    r_quo   <= {r_quo[W-2:0], div_ge};
                    r_dnum  <= {r_dnum[W-2:0], 1'b0};
                    r_cnt   <= r_cnt + CW'(1);
                    if (r_cnt == CW'(W - 1)) begin
                        r_state <= S_DIVW;
                    end
                end
                S_DIVW: begin
                    r_step  <= r_step + 5'd1;
                    r_state <= S_RUN;
                end
                S_DONE: begin
                    // load the result once the output register is free
                    if (out_free) begin
                        r_out.filtered_angle <= ang_out;
                        r_out.snapped        <= r_snap;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `KABF_ASSERT_NEXT(a_accept_starts, in_acc, r_state == S_DT1,
        "accepted request did not start")
    `KABF_ASSERT_NEXT(a_snap_keeps_bias, r_state == S_DT1 && r_snap,
        $stable(r_bias) && $stable(r_p0), "snap changed bias or covariance")
    `KABF_ASSERT_NOW(a_div_positive, r_state == S_DIV || r_state == S_DIVW, s_pos,
        "division by nonpositive variance")
    `KABF_ASSERT_NOW(a_done_step_clear, r_state == S_DONE, r_step == '0,
        "program did not end at its last step")

endmodule
